### sv/assert_macros.svh
// Shared assertion forms for the skinning unit checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LBS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbs: implication check failed");

// next-cycle implication
`define LBS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbs: next-cycle check failed");

`endif

### sv/lbs_pkg.sv
`default_nettype none
package lbs_pkg;

  localparam int WORDS_PER_BONE = 12;
  localparam int SLOT_W         = 4;
  localparam int WEIGHT_W       = 17;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

  localparam int PROD_W = 64;
  localparam int SUM_W  = 66;
  localparam int P_W    = 50;
  localparam int PW_W   = 68;
  localparam int C_W    = 51;
  localparam int ACC_W  = 53;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SKIN = 1'b1
  } opcode_t;

  typedef logic [31:0] word_t;
  typedef logic [WORDS_PER_BONE-1:0][31:0] row_t;

  // stage load enables shared between top and the per-bone datapath
  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
  } pipe_en_t;

  function automatic logic [WEIGHT_W-1:0] weight_clamp(input logic [WEIGHT_W-1:0] w);
    weight_clamp = (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
  endfunction

endpackage
`default_nettype wire

### sv/lbs_palette.sv
`default_nettype none
module lbs_palette #(
  parameter int BONE_COUNT = 64,
  parameter int BW         = 6
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [BW-1:0]             wr_bone,
  input  wire logic [lbs_pkg::SLOT_W-1:0] wr_slot,
  input  wire lbs_pkg::word_t            wr_data,
  input  wire logic                      rd_en,
  input  wire logic [BW-1:0]             rd_bone,
  output lbs_pkg::row_t                  rd_row_r
);
  import lbs_pkg::*;

  row_t mem [BONE_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_bone][wr_slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= mem[rd_bone];
    end
  end

endmodule
`default_nettype wire

### sv/lbs_bone_xform.sv
`default_nettype none
module lbs_bone_xform (
  input  wire logic                        clk,
  input  wire lbs_pkg::pipe_en_t           pen,
  input  wire logic signed [31:0]          pos_x,
  input  wire logic signed [31:0]          pos_y,
  input  wire logic signed [31:0]          pos_z,
  input  wire lbs_pkg::row_t               row,
  input  wire logic                        act,
  input  wire logic [lbs_pkg::WEIGHT_W-1:0] weight,
  output logic signed [lbs_pkg::C_W-1:0]   contrib_r [3]
);
  import lbs_pkg::*;

  row_t                     m;
  logic signed [PROD_W-1:0] prod_nxt [3][3];
  logic signed [PROD_W-1:0] prod_r   [3][3];
  logic signed [31:0]       tr_r     [3];
  logic [WEIGHT_W-1:0]      w2_r;
  logic signed [SUM_W-1:0]  sum      [3];
  logic signed [P_W-1:0]    p_nxt    [3];
  logic signed [P_W-1:0]    p_r      [3];
  logic [WEIGHT_W-1:0]      w3_r;
  logic signed [PW_W-1:0]   pw       [3];

  // inactive bones see a zero matrix so unread entries never leak in
  assign m = act ? row : '0;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_nxt[c][0] = pos_x * $signed(m[c]);
      prod_nxt[c][1] = pos_y * $signed(m[3 + c]);
      prod_nxt[c][2] = pos_z * $signed(m[6 + c]);
    end
  end

  always_ff @(posedge clk) begin
    if (pen.en2) begin
      prod_r <= prod_nxt;
      for (int c = 0; c < 3; c++) begin
        tr_r[c] <= $signed(m[9 + c]);
      end
      w2_r <= act ? weight : '0;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c]   = SUM_W'(prod_r[c][0]) + SUM_W'(prod_r[c][1]) + SUM_W'(prod_r[c][2]);
      p_nxt[c] = $signed(sum[c][SUM_W-1:16]) + P_W'(tr_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (pen.en3) begin
      p_r  <= p_nxt;
      w3_r <= w2_r;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pw[c] = PW_W'(p_r[c]) * PW_W'($signed({1'b0, w3_r}));
    end
  end

  always_ff @(posedge clk) begin
    if (pen.en4) begin
      for (int c = 0; c < 3; c++) begin
        contrib_r[c] <= pw[c][C_W+15:16];
      end
    end
  end

endmodule
`default_nettype wire

### sv/linear_blend_vertex_skinning_unit.sv
// Skin path: palette read, product, sum, weight and output registers, then out_valid.
// One request per cycle unless stalled; skin requests flow through the bone datapath.
// Loads in range write one palette word at the accept edge and produce no result.
// Reset clears the pipeline valid bits only; palette words are undefined until loaded.
`default_nettype none
module linear_blend_vertex_skinning_unit #(
  parameter int BONE_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [9:0]  in_load_address,
  input  wire logic signed [31:0] in_load_value,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic [16:0] in_weight_a,
  input  wire logic [16:0] in_weight_b,
  input  wire logic [16:0] in_weight_c,
  input  wire logic [16:0] in_weight_d,
  input  wire logic [23:0] in_bone_set,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_skinned_x,
  output logic signed [31:0] out_skinned_y,
  output logic signed [31:0] out_skinned_z,
  output logic             out_overflow_flag
);
  import lbs_pkg::*;

  localparam int BW        = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
  localparam int PAL_WORDS = BONE_COUNT * WORDS_PER_BONE;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;
  pipe_en_t pen;
  logic accept;

  // load address split: addr / 12 via reciprocal, exact for 10-bit addresses
  logic [19:0] qm;
  logic [7:0]  q;
  logic [9:0]  rem;
  logic        addr_ok;
  logic        wr_en;

  logic [WEIGHT_W-1:0] w_in [4];
  logic [7:0]          bx   [4];
  logic                act_nxt [4];
  logic                act_r   [4];
  logic [WEIGHT_W-1:0] w_r     [4];
  logic signed [31:0]  px_r, py_r, pz_r;
  row_t                row_r   [4];
  logic signed [C_W-1:0] contrib [4][3];

  logic signed [ACC_W-1:0] acc [3];
  logic signed [31:0]      sat [3];
  logic                    ovf [3];

  assign en5 = !v5_r || !out_stall;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign pen = '{en2: en2, en3: en3, en4: en4};

  assign in_stall = !en1;
  assign accept   = in_valid && en1;

  assign qm      = 20'(in_load_address) * 20'd683;
  assign q       = {1'b0, qm[19:13]};
  assign rem     = in_load_address - (10'({q, 3'b000}) + 10'({q, 2'b00}));
  assign addr_ok = {2'b00, in_load_address} < 12'(PAL_WORDS);
  assign wr_en   = accept && (opcode_t'(in_opcode) == OP_LOAD) && addr_ok;

  assign w_in[0] = in_weight_a;
  assign w_in[1] = in_weight_b;
  assign w_in[2] = in_weight_c;
  assign w_in[3] = in_weight_d;

  // a bone counts only if no weight up to its own is zero and its index is in range
  always_comb begin
    logic run;
    run = 1'b1;
    for (int k = 0; k < 4; k++) begin
      bx[k]      = {2'b00, in_bone_set[6*k +: 6]};
      run        = run && (w_in[k] != '0);
      act_nxt[k] = run && (32'(bx[k]) < BONE_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= accept && (opcode_t'(in_opcode) == OP_SKIN);
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      px_r <= in_pos_x;
      py_r <= in_pos_y;
      pz_r <= in_pos_z;
      for (int k = 0; k < 4; k++) begin
        act_r[k] <= act_nxt[k];
        w_r[k]   <= weight_clamp(w_in[k]);
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bone
    lbs_palette #(
      .BONE_COUNT(BONE_COUNT),
      .BW        (BW)
    ) u_pal (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_bone (q[BW-1:0]),
      .wr_slot (rem[SLOT_W-1:0]),
      .wr_data (in_load_value),
      .rd_en   (en1),
      .rd_bone (bx[k][BW-1:0]),
      .rd_row_r(row_r[k])
    );

    lbs_bone_xform u_xf (
      .clk      (clk),
      .pen      (pen),
      .pos_x    (px_r),
      .pos_y    (py_r),
      .pos_z    (pz_r),
      .row      (row_r[k]),
      .act      (act_r[k]),
      .weight   (w_r[k]),
      .contrib_r(contrib[k])
    );
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = ACC_W'(contrib[0][c]) + ACC_W'(contrib[1][c])
             + ACC_W'(contrib[2][c]) + ACC_W'(contrib[3][c]);
      if (acc[c] > ACC_W'(64'sd2147483647)) begin
        sat[c] = 32'sh7fffffff;
        ovf[c] = 1'b1;
      end else if (acc[c] < ACC_W'(-64'sd2147483648)) begin
        sat[c] = 32'sh80000000;
        ovf[c] = 1'b1;
      end else begin
        sat[c] = acc[c][31:0];
        ovf[c] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_skinned_x     <= sat[0];
      out_skinned_y     <= sat[1];
      out_skinned_z     <= sat[2];
      out_overflow_flag <= ovf[0] || ovf[1] || ovf[2];
    end
  end

  assign out_valid = v5_r;

endmodule
`default_nettype wire

### sv/lbs_checker.sv
`default_nettype none
`include "assert_macros.svh"
module lbs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic signed [31:0] out_skinned_x,
  input wire logic signed [31:0] out_skinned_y,
  input wire logic signed [31:0] out_skinned_z,
  input wire logic        out_overflow_flag
);

  `LBS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `LBS_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_skinned_x) && $stable(out_skinned_y) && $stable(out_skinned_z))
  `LBS_ASSERT_IMP(a_empty_takes, !out_valid, !in_stall)
  `LBS_ASSERT_IMP(a_ovf_sat, out_valid && out_overflow_flag, (out_skinned_x == 32'sh7fffffff) || (out_skinned_x == 32'sh80000000) || (out_skinned_y == 32'sh7fffffff) || (out_skinned_y == 32'sh80000000) || (out_skinned_z == 32'sh7fffffff) || (out_skinned_z == 32'sh80000000))

endmodule

bind linear_blend_vertex_skinning_unit lbs_checker u_lbs_checker (.*);
`default_nettype wire
